### hdl/number_to_ascii_formatter_core_defines.svh
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core_defines
// assertion macros shared by the formatter modules
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NTA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define NTA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define NTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### hdl/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// types, constants and helpers of the number-to-ascii formatter
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int ValueW    = 32;
  localparam int CmdW      = 2;
  localparam int CharW     = 7;
  localparam int BcdDigits = 10;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int SrW       = 44;
  localparam int CntW      = 5;
  localparam int PreW      = 2;

  localparam int DecDigits = 10;
  localparam int HexDigits = 8;
  localparam int OctDigits = 11;
  localparam int BinDigits = 16;

  localparam logic [CharW-1:0] AsciiZero  = 7'd48;
  localparam logic [CharW-1:0] AsciiUpA   = 7'h41;
  localparam logic [CharW-1:0] AsciiMinus = 7'h2d;
  localparam logic [CharW-1:0] AsciiX     = 7'h78;

  typedef enum logic [CmdW-1:0] {
    CmdDec = 2'd0,
    CmdHex = 2'd1,
    CmdOct = 2'd2,
    CmdBin = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StPre,
    StSkip,
    StEmit
  } state_e;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    logic [CharW-1:0] dw;
    dw = {3'b000, d};
    if (d > 4'd9) begin
      return AsciiUpA + dw - 7'd10;
    end
    return AsciiZero + dw;
  endfunction

endpackage

### hdl/nta_bcd_unit.sv
// ----------------------------------------------------------------------------
// nta_bcd_unit
// shift-and-add-3 binary to bcd converter, one bit per cycle
// ----------------------------------------------------------------------------
`include "number_to_ascii_formatter_core_defines.svh"

module nta_bcd_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nta_pkg::ValueW-1:0]   mag_i,
  output logic                         done_o,
  output logic [nta_pkg::BcdW-1:0]     bcd_o
);
  import nta_pkg::*;

  localparam int StepW = $clog2(ValueW);
  localparam logic [StepW-1:0] LastStep = StepW'(ValueW - 1);

  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d, adj;
  logic [StepW-1:0]  step_q;
  logic              busy_q, done_q;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
    bcd_d = {adj[BcdW-2:0], bin_q[ValueW-1]};
    bin_d = {bin_q[ValueW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= mag_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  `NTA_ASSERT_IMPL(a_start_idle, clk_i, rst_ni, start_i, !busy_q, "start while converting")
  `NTA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q, "done held over two cycles")
  `NTA_ASSERT_NEXT(a_last_step, clk_i, rst_ni, busy_q && step_q == LastStep && !start_i, done_q && !busy_q, "conversion did not finish after last step")

endmodule

### hdl/number_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core
// formats a 32-bit value as ascii text in decimal, hex or octal, or its low 16 bits in binary
// ----------------------------------------------------------------------------
// One word in gives 1 to 16 character words out, most significant digit first,
// with last_o set on the final one; in_ready_o is high only while idle. Decimal
// runs the magnitude through a bit-serial bcd converter, then emits the optional
// '-' and the digits; hex, octal and binary go straight to output. Leading zeros
// are dropped one digit per cycle, except in binary. Every radix walks a fixed
// number of digit slots (10 decimal, 8 hex, 11 octal, 16 binary), a slot being
// either a skipped zero or an emitted digit. A new word is taken only after the
// last character of the current one has been loaded; output stalls hold back
// the prefix and digit output.
`include "number_to_ascii_formatter_core_defines.svh"

module number_to_ascii_formatter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nta_pkg::CmdW-1:0]    cmd_i,
  input  logic [nta_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nta_pkg::CharW-1:0]   char_code_o,
  output logic                        last_o
);
  import nta_pkg::*;

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [CntW-1:0]   cnt_q;
  logic [PreW-1:0]   pre_cnt_q;
  logic [SrW-1:0]    sr_q, sr_shift;
  logic              out_valid_q, out_last_q;
  logic [CharW-1:0]  out_char_q;

  logic              accept, slot_free, skip_cond;
  logic              bcd_start, bcd_done;
  logic [BcdW-1:0]   bcd;
  logic [ValueW-1:0] mag;
  logic [3:0]        top_digit;
  logic              load_out, shift_en, pre_dec, ld_last;
  logic [CharW-1:0]  ld_char;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign mag       = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;

  nta_bcd_unit u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .mag_i   (mag),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  // digit at the top of the shift register and the shift per radix
  always_comb begin
    case (cmd_q)
      CmdDec, CmdHex: begin
        top_digit = sr_q[SrW-1 -: 4];
        sr_shift  = {sr_q[SrW-5:0], 4'b0000};
      end
      CmdOct: begin
        top_digit = {1'b0, sr_q[SrW-1 -: 3]};
        sr_shift  = {sr_q[SrW-4:0], 3'b000};
      end
      default: begin
        top_digit = {3'b000, sr_q[SrW-1]};
        sr_shift  = {sr_q[SrW-2:0], 1'b0};
      end
    endcase
  end

  assign skip_cond = (cmd_q != CmdBin) && (cnt_q > CntW'(1)) && (top_digit == 4'd0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = (cmd_e'(cmd_i) == CmdDec) ? StConv : StPre;
        end
      end
      StConv: begin
        if (bcd_done) begin
          state_d = StPre;
        end
      end
      StPre: begin
        if (pre_cnt_q == '0) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (!skip_cond) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free && cnt_q == CntW'(1)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    bcd_start  = 1'b0;
    load_out   = 1'b0;
    shift_en   = 1'b0;
    pre_dec    = 1'b0;
    ld_char    = AsciiZero;
    ld_last    = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        bcd_start  = accept && (cmd_e'(cmd_i) == CmdDec);
      end
      StPre: begin
        if (pre_cnt_q != '0 && slot_free) begin
          load_out = 1'b1;
          pre_dec  = 1'b1;
          if (cmd_q == CmdDec) begin
            ld_char = AsciiMinus;
          end else if (pre_cnt_q == PreW'(1)) begin
            ld_char = AsciiX;
          end else begin
            ld_char = AsciiZero;
          end
        end
      end
      StSkip: begin
        shift_en = skip_cond;
      end
      StEmit: begin
        if (slot_free) begin
          load_out = 1'b1;
          shift_en = 1'b1;
          ld_char  = digit_char(top_digit);
          ld_last  = (cnt_q == CntW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= CmdDec;
      cnt_q       <= '0;
      pre_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cmd_q <= cmd_e'(cmd_i);
        case (cmd_e'(cmd_i))
          CmdDec: begin
            cnt_q     <= CntW'(DecDigits);
            pre_cnt_q <= value_i[ValueW-1] ? PreW'(1) : '0;
          end
          CmdHex: begin
            cnt_q     <= CntW'(HexDigits);
            pre_cnt_q <= PreW'(2);
          end
          CmdOct: begin
            cnt_q     <= CntW'(OctDigits);
            pre_cnt_q <= '0;
          end
          default: begin
            cnt_q     <= CntW'(BinDigits);
            pre_cnt_q <= '0;
          end
        endcase
      end else begin
        if (shift_en) begin
          cnt_q <= cnt_q - 1'b1;
        end
        if (pre_dec) begin
          pre_cnt_q <= pre_cnt_q - 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (cmd_e'(cmd_i))
        CmdHex:  sr_q <= {value_i, 12'b0};
        CmdOct:  sr_q <= {1'b0, value_i, 11'b0};
        default: sr_q <= {value_i[15:0], 28'b0};
      endcase
    end else if (bcd_done) begin
      sr_q <= {bcd, 4'b0000};
    end else if (shift_en) begin
      sr_q <= sr_shift;
    end
    if (load_out) begin
      out_char_q <= ld_char;
      out_last_q <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;
  assign last_o      = out_last_q;

  `NTA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != StIdle, "accepted word did not start work")
  `NTA_ASSERT_IMPL(a_emit_cnt, clk_i, rst_ni, state_q == StEmit || state_q == StSkip, cnt_q != '0, "digit count ran out")
  `NTA_ASSERT_IMPL(a_done_conv, clk_i, rst_ni, bcd_done, state_q == StConv && cmd_q == CmdDec, "bcd result outside decimal conversion")

endmodule

### tb/number_to_ascii_formatter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core_tb
// self-checking bench: drives values in all four radix modes through the
// valid/ready input, predicts the ascii text of each one and compares every
// character word and its last flag as it leaves, under random input gaps and
// output stalls
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core_tb;
  import nta_pkg::*;

  localparam logic [7:0] CharZero  = "0";
  localparam logic [7:0] CharUpA   = "A";
  localparam logic [7:0] CharMinus = "-";
  localparam logic [7:0] CharLowX  = "x";

  localparam int NumRandomValues = 280;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  // predicted character stream and its comparison against the output port
  class char_stream_checker;
    text_char_t  expected_chars[$];
    int unsigned values_by_radix[4];
    int unsigned chars_checked;
    int unsigned mismatches;

    function logic [7:0] digit_code(logic [3:0] d);
      if (d > 4'd9) begin
        return CharUpA + 8'(d) - 8'd10;
      end
      return CharZero + 8'(d);
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void add_value_text(cmd_e radix, logic [ValueW-1:0] value);
      logic [7:0]        txt[$];
      logic [7:0]        digits[$];
      logic [ValueW-1:0] mag;
      logic [ValueW-1:0] base;
      int                b;
      text_char_t        ch;
      mag = value;
      base = 32'd10;
      values_by_radix[radix]++;
      case (radix)
        CmdDec: begin
          if (value[ValueW-1]) begin
            txt.push_back(CharMinus);
            mag = -value;
          end
        end
        CmdHex: begin
          base = 32'd16;
          txt.push_back(CharZero);
          txt.push_back(CharLowX);
        end
        CmdOct: base = 32'd8;
        default: base = 32'd2;
      endcase
      if (radix == CmdBin) begin
        for (b = BinDigits - 1; b >= 0; b--) begin
          txt.push_back(CharZero + 8'(value[b]));
        end
      end else begin
        // do-while gives a single '0' for a zero magnitude
        do begin
          digits.push_front(digit_code(4'(mag % base)));
          mag = mag / base;
        end while (mag != 0);
        foreach (digits[k]) txt.push_back(digits[k]);
      end
      foreach (txt[k]) begin
        ch.code = txt[k][CharW-1:0];
        ch.last = (k == txt.size() - 1);
        expected_chars.push_back(ch);
      end
    endfunction

    function void check_char(logic [CharW-1:0] code, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: char word with nothing pending: expected none, actual code 0x%02h last %0b",
                 $time, code, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (code !== want.code) begin
        $display("%0t: char_code mismatch: expected 0x%02h, actual 0x%02h",
                 $time, want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CmdW-1:0]   cmd_i = CmdDec;
  logic [ValueW-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CharW-1:0]  char_code_o;
  logic              last_o;

  char_stream_checker sb = new();

  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  number_to_ascii_formatter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // monitor both handshakes on the same edge the block sees them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.add_value_text(cmd_e'(cmd_i), value_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_char(char_code_o, last_o);
      end
    end
  end

  // output stall pattern: stretches of always-ready, coin flips, sparse, periodic
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ((rx_left % 10) < 3);
      endcase
    end
  end

  task automatic send_word(input cmd_e radix, input logic [ValueW-1:0] value);
    in_valid_i <= 1'b1;
    cmd_i      <= radix;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 5);
    end
  endtask

  // hold off until every predicted char word has left the block
  task automatic drain_text();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 20));
      1: return 32'(1) << $urandom_range(0, 31);
      2: return -32'($urandom_range(1, 20));
      3: return (32'(1) << $urandom_range(1, 31)) - 32'd1;
      4: return 32'h8000_0000 ^ 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, sign and width extremes in every radix
    send_word(CmdDec, 32'd0);
    send_word(CmdDec, 32'd1);
    send_word(CmdDec, 32'hFFFF_FFFF);
    send_word(CmdDec, 32'h7FFF_FFFF);
    send_word(CmdDec, 32'h8000_0000);
    send_word(CmdDec, 32'd10);
    send_word(CmdDec, 32'd1_000_000_000);
    send_word(CmdDec, 32'hC465_3600);
    send_word(CmdHex, 32'd0);
    send_word(CmdHex, 32'hFFFF_FFFF);
    send_word(CmdHex, 32'h0000_000A);
    send_word(CmdHex, 32'h0000_0010);
    send_word(CmdHex, 32'h8000_0000);
    send_word(CmdOct, 32'd0);
    send_word(CmdOct, 32'hFFFF_FFFF);
    send_word(CmdOct, 32'd7);
    send_word(CmdOct, 32'd8);
    send_word(CmdBin, 32'd0);
    send_word(CmdBin, 32'hFFFF_FFFF);
    send_word(CmdBin, 32'hFFFF_0000);
    send_word(CmdBin, 32'h0000_A5A5);
    drain_text();

    for (int n = 0; n < NumRandomValues; n++) begin
      send_word(cmd_e'($urandom_range(0, 3)), pick_value());
      if (n % 70 == 69) drain_text();
    end

    drain_text();
    repeat (100) @(posedge clk_i);
    $display("covered %0d values: %0d decimal, %0d hex, %0d octal, %0d binary",
             sb.values_by_radix[CmdDec] + sb.values_by_radix[CmdHex] +
             sb.values_by_radix[CmdOct] + sb.values_by_radix[CmdBin],
             sb.values_by_radix[CmdDec], sb.values_by_radix[CmdHex],
             sb.values_by_radix[CmdOct], sb.values_by_radix[CmdBin]);
    $display("%0d char words compared, %0d mismatches", sb.chars_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d char words still pending", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/nta_pkg.sv
hdl/nta_bcd_unit.sv
hdl/number_to_ascii_formatter_core.sv
tb/number_to_ascii_formatter_core_tb.sv
